FILE: sv/lkc_pkg.sv
// Shared types and codes of the LRU-K cache policy core.
package lkc_pkg;

  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_PUT    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] WHERE_MISS  = 2'd0;
  localparam logic [1:0] WHERE_CACHE = 2'd1;
  localparam logic [1:0] WHERE_HIST  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSCAN,
    ST_HSCAN,
    ST_UPDATE,
    ST_RESP
  } lkc_state_e;

  // Per-cycle verdict of the shared scan unit.
  typedef struct packed {
    logic                match;
    logic                better;
    logic [STAMP_W-1:0]  age;
  } lkc_scan_t;

endpackage

FILE: sv/lkc_scan_unit.sv
// Shared scan unit: key compare and stamp age compare for one table slot.
module lkc_scan_unit #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0]        slot_key_i,
  input  logic [KEY_WIDTH-1:0]        key_i,
  input  logic                        slot_valid_i,
  input  logic [lkc_pkg::STAMP_W-1:0] now_i,
  input  logic [lkc_pkg::STAMP_W-1:0] stamp_i,
  input  logic [lkc_pkg::STAMP_W-1:0] best_age_i,
  input  logic                        have_best_i,
  output lkc_pkg::lkc_scan_t          scan_o
);

  logic [lkc_pkg::STAMP_W-1:0] age;

  // Ages are taken modulo the stamp width, so counter wrap is harmless.
  assign age = now_i - stamp_i;

  always_comb begin
    scan_o.match  = slot_valid_i && (slot_key_i == key_i);
    scan_o.better = slot_valid_i && (!have_best_i || (age > best_age_i));
    scan_o.age    = age;
  end

endmodule

FILE: sv/lru_k_cache_policy_core.sv
// Top level of the LRU-K cache policy core: sequencer, tables and config registers.
//
// An item is accepted when start_i is high and busy_o is low; busy_o then stays high
// until the single result has been shown for one cycle with done_o high, and the
// receiver must take it in that cycle since it cannot stall the block. A clear or an
// unused command goes from idle straight to the result state. A get or put walks the
// cache table one slot per cycle through the shared scan unit, then on a cache miss
// walks the history table the same way, then passes through the update state, which
// writes the tables, and then through the result state.
// Configuration writes are always accepted and should only be made while idle.
module lru_k_cache_policy_core #(
  parameter int unsigned CAPACITY    = 8,
  parameter int unsigned K_MAX       = 4,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      cmd_i,
  input  logic [31:0]                     key_i,
  input  logic [31:0]                     wdata_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [31:0]                     rdata_o,
  output logic [1:0]                      where_found_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lkc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lkc_pkg::CFG_DAT_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KC_W  = $clog2(K_MAX + 1);
  localparam int unsigned KI_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int unsigned SW    = lkc_pkg::STAMP_W;

  typedef logic [K_MAX-1:0][SW-1:0] stm_t;
  typedef struct packed {
    stm_t            s;
    logic [KC_W-1:0] n;
  } push_t;

  // Record stamp t and keep only the last k stamps, oldest at index 0.
  function automatic push_t push_stamp(stm_t s, logic [KC_W-1:0] n,
                                       logic [SW-1:0] t, logic [KC_W-1:0] k);
    stm_t            a;
    stm_t            b;
    logic [KC_W-1:0] cnt;
    logic [KC_W-1:0] m;
    push_t           r;
    a   = s;
    cnt = n;
    if (cnt >= KC_W'(K_MAX)) begin
      for (int i = 0; i < K_MAX - 1; i++) a[i] = a[i+1];
      cnt = KC_W'(K_MAX - 1);
    end
    a[cnt[KI_W-1:0]] = t;
    cnt = cnt + 1'b1;
    m   = (cnt > k) ? (cnt - k) : '0;
    b   = a;
    for (int i = 0; i < K_MAX; i++) begin
      for (int mm = 0; mm < K_MAX; mm++) begin
        if (m == KC_W'(mm)) b[i] = a[(i + mm > K_MAX - 1) ? K_MAX - 1 : i + mm];
      end
    end
    r.s = b;
    r.n = cnt - m;
    return r;
  endfunction

  // Configuration registers.
  logic [3:0] cap_q;
  logic [2:0] pk_q;
  logic [CNT_W-1:0] cap_eff;
  logic [KC_W-1:0]  k_eff;

  always_comb begin
    if (cap_q == 4'd0) cap_eff = CNT_W'(1);
    else if (int'(cap_q) > CAPACITY) cap_eff = CNT_W'(CAPACITY);
    else cap_eff = CNT_W'(cap_q);
    if (pk_q == 3'd0) k_eff = KC_W'(1);
    else if (int'(pk_q) > K_MAX) k_eff = KC_W'(K_MAX);
    else k_eff = KC_W'(pk_q);
  end

  // Tables. Valid bits and stamp counts reset; the rest holds payload only.
  logic [KEY_WIDTH-1:0]   c_key_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] c_val_q [CAPACITY];
  stm_t                   c_stm_q [CAPACITY];
  logic [KC_W-1:0]        c_cnt_q [CAPACITY];
  logic [CAPACITY-1:0]    c_vld_q;
  logic [KEY_WIDTH-1:0]   h_key_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] h_val_q [CAPACITY];
  stm_t                   h_stm_q [CAPACITY];
  logic [KC_W-1:0]        h_cnt_q [CAPACITY];
  logic [SW-1:0]          h_ord_q [CAPACITY];
  logic [CAPACITY-1:0]    h_vld_q;

  // Sequencer state and the item in flight.
  lkc_pkg::lkc_state_e    state_q, state_d;
  logic [SW-1:0]          counter_q;
  logic [SW-1:0]          now_q;
  logic [1:0]             cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]       idx_q;
  logic [IDX_W-1:0]       slot_q;
  logic                   hit_c_q, hit_h_q;
  logic [CNT_W-1:0]       ccnt_q, hcnt_q;
  logic [IDX_W-1:0]       cfree_q, hfree_q, vic_q, tail_q;
  logic                   hfree_ok_q;
  logic [SW-1:0]          best_q;
  logic                   have_q;
  logic                   res_hit_q;
  logic [31:0]            res_data_q;
  logic [1:0]             res_where_q;

  // Shared scan unit, fed from the table being walked.
  logic [KEY_WIDTH-1:0] sc_key;
  logic                 sc_vld;
  logic [SW-1:0]        sc_stamp;
  lkc_pkg::lkc_scan_t   scan;

  always_comb begin
    if (state_q == lkc_pkg::ST_CSCAN) begin
      sc_key   = c_key_q[idx_q];
      sc_vld   = c_vld_q[idx_q];
      sc_stamp = c_stm_q[idx_q][0];
    end else begin
      sc_key   = h_key_q[idx_q];
      sc_vld   = h_vld_q[idx_q];
      sc_stamp = h_ord_q[idx_q];
    end
  end

  lkc_scan_unit #(.KEY_WIDTH(KEY_WIDTH)) u_scan (
    .slot_key_i   (sc_key),
    .key_i        (key_q),
    .slot_valid_i (sc_vld),
    .now_i        (now_q),
    .stamp_i      (sc_stamp),
    .best_age_i   (best_q),
    .have_best_i  (have_q),
    .scan_o       (scan)
  );

  // Update decisions taken in the update cycle.
  logic       idx_last;
  push_t      pushed;
  stm_t       fresh;
  logic       promote;
  logic       room;
  logic       evict;
  logic [IDX_W-1:0] dst, ins;
  logic       accept;

  assign accept   = start_i && (state_q == lkc_pkg::ST_IDLE);
  assign idx_last = (idx_q == IDX_W'(CAPACITY - 1));

  always_comb begin
    if (hit_c_q) pushed = push_stamp(c_stm_q[slot_q], c_cnt_q[slot_q], now_q, k_eff);
    else         pushed = push_stamp(h_stm_q[slot_q], h_cnt_q[slot_q], now_q, k_eff);
    // Stamp list of a newly inserted history entry: only the current access.
    fresh    = '0;
    fresh[0] = now_q;
    promote = hit_h_q && (pushed.n == k_eff);
    room    = ccnt_q < cap_eff;
    dst     = room ? cfree_q : vic_q;
    evict   = hcnt_q >= cap_eff;
    if (!hfree_ok_q) ins = tail_q;
    else if (evict && (tail_q < hfree_q)) ins = tail_q;
    else ins = hfree_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkc_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_i == lkc_pkg::CMD_GET || cmd_i == lkc_pkg::CMD_PUT) state_d = lkc_pkg::ST_CSCAN;
          else state_d = lkc_pkg::ST_RESP;
        end
      end
      lkc_pkg::ST_CSCAN: begin
        if (scan.match) state_d = lkc_pkg::ST_UPDATE;
        else if (idx_last) state_d = lkc_pkg::ST_HSCAN;
      end
      lkc_pkg::ST_HSCAN: begin
        if (scan.match || idx_last) state_d = lkc_pkg::ST_UPDATE;
      end
      lkc_pkg::ST_UPDATE: state_d = lkc_pkg::ST_RESP;
      lkc_pkg::ST_RESP:   state_d = lkc_pkg::ST_IDLE;
      default:            state_d = lkc_pkg::ST_IDLE;
    endcase
  end

  // Control state, valid bits and stamp counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkc_pkg::ST_IDLE;
      cap_q       <= 4'd8;
      pk_q        <= 3'd2;
      counter_q   <= '0;
      c_vld_q     <= '0;
      h_vld_q     <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        c_cnt_q[i] <= '0;
        h_cnt_q[i] <= '0;
      end
      idx_q       <= '0;
      hit_c_q     <= 1'b0;
      hit_h_q     <= 1'b0;
      hfree_ok_q  <= 1'b0;
      have_q      <= 1'b0;
      ccnt_q      <= '0;
      hcnt_q      <= '0;
      res_hit_q   <= 1'b0;
      res_where_q <= lkc_pkg::WHERE_MISS;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == lkc_pkg::CFG_CAPACITY) cap_q <= cfg_wdata_i[3:0];
        else if (cfg_index_i == lkc_pkg::CFG_PROMOTE) pk_q <= cfg_wdata_i[2:0];
      end
      unique case (state_q)
        lkc_pkg::ST_IDLE: begin
          if (accept) begin
            res_hit_q   <= 1'b0;
            res_where_q <= lkc_pkg::WHERE_MISS;
            idx_q       <= '0;
            hit_c_q     <= 1'b0;
            hit_h_q     <= 1'b0;
            hfree_ok_q  <= 1'b0;
            have_q      <= 1'b0;
            ccnt_q      <= '0;
            hcnt_q      <= '0;
            if (cmd_i == lkc_pkg::CMD_CLEAR) begin
              c_vld_q <= '0;
              h_vld_q <= '0;
              for (int i = 0; i < CAPACITY; i++) begin
                c_cnt_q[i] <= '0;
                h_cnt_q[i] <= '0;
              end
            end else if (cmd_i == lkc_pkg::CMD_GET || cmd_i == lkc_pkg::CMD_PUT) begin
              counter_q <= counter_q + 1'b1;
            end
          end
        end
        lkc_pkg::ST_CSCAN: begin
          if (scan.match) begin
            hit_c_q <= 1'b1;
          end else begin
            if (sc_vld) ccnt_q <= ccnt_q + 1'b1;
            if (idx_last) begin
              idx_q  <= '0;
              have_q <= 1'b0;
            end else begin
              idx_q <= idx_q + 1'b1;
              if (scan.better) have_q <= 1'b1;
            end
          end
        end
        lkc_pkg::ST_HSCAN: begin
          if (scan.match) begin
            hit_h_q <= 1'b1;
          end else begin
            if (sc_vld) hcnt_q <= hcnt_q + 1'b1;
            else hfree_ok_q <= 1'b1;
            if (scan.better) have_q <= 1'b1;
            idx_q <= idx_q + 1'b1;
          end
        end
        lkc_pkg::ST_UPDATE: begin
          if (hit_c_q) begin
            c_cnt_q[slot_q] <= pushed.n;
            res_hit_q       <= 1'b1;
            res_where_q     <= lkc_pkg::WHERE_CACHE;
          end else if (hit_h_q) begin
            res_hit_q   <= 1'b1;
            res_where_q <= lkc_pkg::WHERE_HIST;
            if (promote) begin
              if (room) begin
                h_vld_q[slot_q] <= 1'b0;
                h_cnt_q[slot_q] <= '0;
              end else begin
                h_cnt_q[slot_q] <= c_cnt_q[dst];
              end
              c_cnt_q[dst] <= pushed.n;
              c_vld_q[dst] <= 1'b1;
            end else begin
              h_cnt_q[slot_q] <= pushed.n;
            end
          end else if (cmd_q == lkc_pkg::CMD_PUT) begin
            // A miss on put inserts at the history front; a full history drops its tail.
            // When the new entry lands in the tail slot it simply overwrites it.
            if (evict && (ins != tail_q)) begin
              h_vld_q[tail_q] <= 1'b0;
              h_cnt_q[tail_q] <= '0;
            end
            h_cnt_q[ins] <= KC_W'(1);
            h_vld_q[ins] <= 1'b1;
          end
        end
        lkc_pkg::ST_RESP: ;
        default: ;
      endcase
    end
  end

  // Payload: keys, values, stamps, scan bookkeeping and the item itself.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lkc_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_q      <= cmd_i;
          key_q      <= KEY_WIDTH'(key_i);
          val_q      <= VALUE_WIDTH'(wdata_i);
          now_q      <= counter_q;
          res_data_q <= '0;
        end
      end
      lkc_pkg::ST_CSCAN: begin
        if (scan.match) begin
          slot_q <= idx_q;
        end else begin
          if (!sc_vld && (ccnt_q == CNT_W'(idx_q))) cfree_q <= idx_q;
          if (scan.better) begin
            vic_q  <= idx_q;
            best_q <= scan.age;
          end
        end
      end
      lkc_pkg::ST_HSCAN: begin
        if (scan.match) begin
          slot_q <= idx_q;
        end else begin
          if (!sc_vld && !hfree_ok_q) hfree_q <= idx_q;
          if (scan.better) begin
            tail_q <= idx_q;
            best_q <= scan.age;
          end
        end
      end
      lkc_pkg::ST_UPDATE: begin
        if (hit_c_q) begin
          c_stm_q[slot_q] <= pushed.s;
          if (cmd_q == lkc_pkg::CMD_PUT) c_val_q[slot_q] <= val_q;
          else res_data_q <= 32'(c_val_q[slot_q]);
        end else if (hit_h_q) begin
          if (cmd_q != lkc_pkg::CMD_PUT) res_data_q <= 32'(h_val_q[slot_q]);
          if (promote) begin
            if (!room) begin
              // The victim is demoted into the freed history slot, at the front.
              h_key_q[slot_q] <= c_key_q[dst];
              h_val_q[slot_q] <= c_val_q[dst];
              h_stm_q[slot_q] <= c_stm_q[dst];
              h_ord_q[slot_q] <= now_q;
            end
            c_key_q[dst] <= h_key_q[slot_q];
            c_val_q[dst] <= (cmd_q == lkc_pkg::CMD_PUT) ? val_q : h_val_q[slot_q];
            c_stm_q[dst] <= pushed.s;
          end else begin
            h_stm_q[slot_q] <= pushed.s;
            h_ord_q[slot_q] <= now_q;
            if (cmd_q == lkc_pkg::CMD_PUT) h_val_q[slot_q] <= val_q;
          end
        end else if (cmd_q == lkc_pkg::CMD_PUT) begin
          h_key_q[ins]    <= key_q;
          h_val_q[ins]    <= val_q;
          h_stm_q[ins]    <= fresh;
          h_ord_q[ins]    <= now_q;
        end
      end
      lkc_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  assign busy_o        = (state_q != lkc_pkg::ST_IDLE);
  assign done_o        = (state_q == lkc_pkg::ST_RESP);
  assign hit_o         = res_hit_q;
  assign rdata_o       = res_data_q;
  assign where_found_o = res_where_q;
  assign cfg_ready_o   = 1'b1;

endmodule

FILE: sv/lkc_checker.sv
// Port-level checker of the LRU-K cache policy core and its bind.
module lkc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        hit_o,
  input logic [1:0]  where_found_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result shown while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted item did not raise busy");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o) else $error("block stayed busy after its result");

  a_miss_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> where_found_o == lkc_pkg::WHERE_MISS)
    else $error("miss reported with a table code");

  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> where_found_o == lkc_pkg::WHERE_CACHE ||
                        where_found_o == lkc_pkg::WHERE_HIST)
    else $error("hit reported without a table code");

endmodule

bind lru_k_cache_policy_core lkc_checker u_lkc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .hit_o         (hit_o),
  .where_found_o (where_found_o)
);

FILE: tb/tb_lru_k_cache_policy_core.sv
// Self-checking testbench for the LRU-K cache policy core.
`timescale 1ns / 1ps

module tb_lru_k_cache_policy_core;

  localparam int unsigned CAP  = 8;
  localparam int unsigned KMAX = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  cmd_i;
  logic [31:0] key_i;
  logic [31:0] wdata_i;
  logic        done_o;
  logic        hit_o;
  logic [31:0] rdata_o;
  logic [1:0]  where_found_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [lkc_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [lkc_pkg::CFG_DAT_W-1:0] cfg_wdata_i;

  lru_k_cache_policy_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .key_i, .wdata_i,
    .done_o, .hit_o, .rdata_o, .where_found_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_wdata_i
  );

  // One expected lookup outcome.
  typedef struct {
    logic        hit;
    logic [31:0] rdata;
    logic [1:0]  where_found;
  } lookup_t;

  lookup_t lookup_q[$];

  // Shadow copy of the policy state; the stamp lists are oldest first.
  logic [3:0]  sh_capacity;
  logic [2:0]  sh_promote;
  logic [31:0] sh_ckey[CAP], sh_cval[CAP], sh_cst[CAP][KMAX];
  bit          sh_cvld[CAP];
  int          sh_ccnt[CAP];
  logic [31:0] sh_hkey[CAP], sh_hval[CAP], sh_hst[CAP][KMAX], sh_hord[CAP];
  bit          sh_hvld[CAP];
  int          sh_hcnt[CAP];
  logic [31:0] sh_counter;

  int  error_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  bit  run_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_capacity();
    if (sh_capacity == 0) return 1;
    if (sh_capacity > CAP) return CAP;
    return sh_capacity;
  endfunction

  function automatic int eff_promote();
    if (sh_promote == 0) return 1;
    if (sh_promote > KMAX) return KMAX;
    return sh_promote;
  endfunction

  // Appends stamp t to a stamp list and trims it to the last k stamps.
  task automatic record_stamp(inout logic [31:0] st[KMAX], inout int n,
                              input logic [31:0] t, input int k);
    if (n >= KMAX) begin
      for (int m = 0; m < KMAX - 1; m++) st[m] = st[m+1];
      n = KMAX - 1;
    end
    st[n] = t;
    n++;
    while (n > k) begin
      for (int m = 0; m < KMAX - 1; m++) st[m] = st[m+1];
      n--;
    end
  endtask

  function automatic void shadow_reset();
    sh_capacity = 4'd8;
    sh_promote  = 3'd2;
    sh_counter  = '0;
    for (int i = 0; i < CAP; i++) begin
      sh_cvld[i] = 0; sh_hvld[i] = 0; sh_ccnt[i] = 0; sh_hcnt[i] = 0;
      sh_ckey[i] = '0; sh_cval[i] = '0; sh_hkey[i] = '0; sh_hval[i] = '0;
      sh_hord[i] = '0;
      for (int m = 0; m < KMAX; m++) begin
        sh_cst[i][m] = '0; sh_hst[i][m] = '0;
      end
    end
  endfunction

  // Index of the valid history entry placed at the front longest ago.
  function automatic int hist_tail_slot(logic [31:0] now);
    int best = -1;
    logic [31:0] best_age = '0, age;
    for (int i = 0; i < CAP; i++) begin
      if (!sh_hvld[i]) continue;
      age = now - sh_hord[i];
      if (best < 0 || age > best_age) begin
        best = i; best_age = age;
      end
    end
    return best;
  endfunction

  // Works out the outcome of one access and advances the shadow state.
  task automatic predict_access(input logic [1:0] cmd, input logic [31:0] key,
                                input logic [31:0] wdata, output lookup_t res);
    logic [31:0] now, ek, ev, age, best_age;
    logic [31:0] es[KMAX];
    int k, cap, ci, hj, d, en, nvalid, s, best;
    res = '{1'b0, 32'd0, lkc_pkg::WHERE_MISS};
    if (cmd == lkc_pkg::CMD_CLEAR) begin
      for (int i = 0; i < CAP; i++) begin
        sh_cvld[i] = 0; sh_hvld[i] = 0; sh_ccnt[i] = 0; sh_hcnt[i] = 0;
      end
      return;
    end
    if (cmd != lkc_pkg::CMD_GET && cmd != lkc_pkg::CMD_PUT) return;
    now = sh_counter;
    sh_counter++;
    k = eff_promote();
    cap = eff_capacity();
    ci = -1;
    for (int i = CAP - 1; i >= 0; i--) if (sh_cvld[i] && sh_ckey[i] == key) ci = i;
    if (ci >= 0) begin
      record_stamp(sh_cst[ci], sh_ccnt[ci], now, k);
      if (cmd == lkc_pkg::CMD_PUT) sh_cval[ci] = wdata;
      else res.rdata = sh_cval[ci];
      res.hit = 1'b1; res.where_found = lkc_pkg::WHERE_CACHE;
      return;
    end
    hj = -1;
    for (int i = CAP - 1; i >= 0; i--) if (sh_hvld[i] && sh_hkey[i] == key) hj = i;
    if (hj >= 0) begin
      record_stamp(sh_hst[hj], sh_hcnt[hj], now, k);
      if (cmd == lkc_pkg::CMD_PUT) sh_hval[hj] = wdata;
      else res.rdata = sh_hval[hj];
      if (sh_hcnt[hj] == k) begin
        // Promotion, with a demotion into the freed history slot if the cache is full.
        ek = sh_hkey[hj]; ev = sh_hval[hj]; en = sh_hcnt[hj];
        es = sh_hst[hj];
        d = -1;
        nvalid = 0;
        for (int i = 0; i < CAP; i++) if (sh_cvld[i]) nvalid++;
        if (nvalid < cap)
          for (int i = CAP - 1; i >= 0; i--) if (!sh_cvld[i]) d = i;
        if (d < 0) begin
          best_age = '0;
          for (int i = 0; i < CAP; i++) begin
            if (!sh_cvld[i]) continue;
            age = now - sh_cst[i][0];
            if (d < 0 || age > best_age) begin
              d = i; best_age = age;
            end
          end
          sh_hkey[hj] = sh_ckey[d]; sh_hval[hj] = sh_cval[d];
          sh_hst[hj] = sh_cst[d]; sh_hcnt[hj] = sh_ccnt[d];
          sh_hord[hj] = now;
        end else begin
          sh_hvld[hj] = 0; sh_hcnt[hj] = 0;
        end
        sh_ckey[d] = ek; sh_cval[d] = ev; sh_cst[d] = es; sh_ccnt[d] = en;
        sh_cvld[d] = 1;
      end else begin
        sh_hord[hj] = now;
      end
      res.hit = 1'b1; res.where_found = lkc_pkg::WHERE_HIST;
      return;
    end
    if (cmd == lkc_pkg::CMD_PUT) begin
      nvalid = 0;
      for (int i = 0; i < CAP; i++) if (sh_hvld[i]) nvalid++;
      if (nvalid >= cap) begin
        best = hist_tail_slot(now);
        if (best >= 0) begin
          sh_hvld[best] = 0; sh_hcnt[best] = 0;
        end
      end
      s = -1;
      for (int i = CAP - 1; i >= 0; i--) if (!sh_hvld[i]) s = i;
      if (s < 0) begin
        s = hist_tail_slot(now);
        if (s < 0) s = 0;
      end
      sh_hkey[s] = key; sh_hval[s] = wdata;
      for (int m = 0; m < KMAX; m++) sh_hst[s][m] = '0;
      sh_hst[s][0] = now; sh_hcnt[s] = 1; sh_hord[s] = now; sh_hvld[s] = 1;
    end
  endtask

  // Sends one item: optional random gap, then start held until the block takes it.
  // Start is left high afterwards; the next gap or drain lowers it.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] key,
                           input logic [31:0] wdata);
    lookup_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= cmd;
    key_i   <= key;
    wdata_i <= wdata;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // Accepted at this edge; the result cannot appear before the next one.
    predict_access(cmd, key, wdata, res);
    lookup_q.push_back(res);
    items_sent++;
  endtask

  // Waits until every expected result has come, plus a short settling gap.
  task automatic drain_results();
    start_i <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [lkc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == lkc_pkg::CFG_CAPACITY) sh_capacity = val[3:0];
    else if (idx == lkc_pkg::CFG_PROMOTE) sh_promote = val[2:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checker: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    lookup_t exp_res;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (lookup_q.size() == 0) begin
        $error("result with no item outstanding");
        error_count++;
      end else begin
        exp_res = lookup_q.pop_front();
        if (hit_o !== exp_res.hit) begin
          $error("hit: expected %0d, got %0d", exp_res.hit, hit_o);
          error_count++;
        end
        if (rdata_o !== exp_res.rdata) begin
          $error("rdata: expected %h, got %h", exp_res.rdata, rdata_o);
          error_count++;
        end
        if (where_found_o !== exp_res.where_found) begin
          $error("where_found: expected %0d, got %0d", exp_res.where_found, where_found_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an item, a result nor a configuration write is taken.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_valid_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!run_done && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Random key drawn mostly from a small pool so that hits, promotions and
  // evictions are frequent, with an occasional fully random key.
  function automatic logic [31:0] pick_key(int pool);
    logic [31:0] base;
    base = 32'hA5C3_0000;
    if ($urandom_range(19) == 0) return $urandom;
    return base + $urandom_range(pool - 1);
  endfunction

  task automatic test_directed_edges();
    // Field extremes, both commands on an empty store, and an unused command.
    send_item(lkc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(lkc_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(lkc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lkc_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678);
    send_item(lkc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(lkc_pkg::CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // A third access after promotion hits the cache.
    send_item(lkc_pkg::CMD_GET, 32'h0000_0000, 32'd0);
    send_item(lkc_pkg::CMD_PUT, 32'h0000_0000, 32'h5555_AAAA);
    send_item(lkc_pkg::CMD_GET, 32'h0000_0000, 32'd0);
    send_item(lkc_pkg::CMD_CLEAR, 32'h0000_0000, 32'd0);
    send_item(lkc_pkg::CMD_GET, 32'h0000_0000, 32'd0);
  endtask

  task automatic test_small_capacity();
    // Capacity of one: once the history is full a put miss evicts, and once the cache is full a promotion demotes.
    write_register(lkc_pkg::CFG_CAPACITY, 32'd1);
    write_register(lkc_pkg::CFG_PROMOTE, 32'd1);
    send_item(lkc_pkg::CMD_PUT, 32'd10, 32'd100);
    send_item(lkc_pkg::CMD_GET, 32'd10, 32'd0);
    send_item(lkc_pkg::CMD_PUT, 32'd11, 32'd110);
    send_item(lkc_pkg::CMD_GET, 32'd11, 32'd0);
    send_item(lkc_pkg::CMD_GET, 32'd10, 32'd0);
    send_item(lkc_pkg::CMD_PUT, 32'd12, 32'd120);
    send_item(lkc_pkg::CMD_GET, 32'd11, 32'd0);
    // Out-of-range register values act as the nearest legal value.
    write_register(lkc_pkg::CFG_CAPACITY, 32'd0);
    write_register(lkc_pkg::CFG_PROMOTE, 32'd0);
    send_item(lkc_pkg::CMD_PUT, 32'd13, 32'd130);
    send_item(lkc_pkg::CMD_GET, 32'd13, 32'd0);
    write_register(lkc_pkg::CFG_CAPACITY, 32'hFFFF_FFFF);
    write_register(lkc_pkg::CFG_PROMOTE, 32'hFFFF_FFFF);
    send_item(lkc_pkg::CMD_GET, 32'd13, 32'd0);
    send_item(lkc_pkg::CMD_PUT, 32'd14, 32'd140);
  endtask

  task automatic random_phase(int count, int pool);
    logic [1:0] cmd;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45) cmd = lkc_pkg::CMD_GET;
      else if (r < 95) cmd = lkc_pkg::CMD_PUT;
      else if (r < 98) cmd = lkc_pkg::CMD_CLEAR;
      else cmd = lkc_pkg::CMD_UNUSED;
      send_item(cmd, pick_key(pool), $urandom);
    end
  endtask

  task automatic test_random_settings();
    int cap_v, k_v;
    for (int phase = 0; phase < 9; phase++) begin
      send_idle_pct = (phase < 3) ? 35 : (phase < 6) ? 70 : 0;
      cap_v = (phase % 3 == 0) ? 8 : $urandom_range(15);
      k_v = (phase % 3 == 1) ? 4 : $urandom_range(7);
      write_register(lkc_pkg::CFG_CAPACITY, 32'(cap_v));
      write_register(lkc_pkg::CFG_PROMOTE, 32'(k_v));
      random_phase(70, (phase % 2) ? 24 : 12);
      // Lower capacity and K with entries still in the tables.
      write_register(lkc_pkg::CFG_CAPACITY, 32'($urandom_range(1, 3)));
      write_register(lkc_pkg::CFG_PROMOTE, 32'd1);
      random_phase(5, 12);
    end
  endtask

  initial begin
    shadow_reset();
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    cmd_i       <= lkc_pkg::CMD_GET;
    key_i       <= '0;
    wdata_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= lkc_pkg::CFG_CAPACITY;
    cfg_wdata_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    test_directed_edges();
    test_small_capacity();
    test_random_settings();

    drain_results();
    repeat (2 * CAP + 10) @(posedge clk_i);
    run_done = 1;
    $display("Covered %0d items and %0d results over directed edges and nine", items_sent,
             results_seen);
    $display("random phases with varied capacity, K, key pools and sender gaps.");
    if (error_count == 0 && lookup_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
